// ===== src/servo_ack_frame_parser_macros.svh =====
// Assertion macros for the servo acknowledge frame parser.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SERVO_ACK_FRAME_PARSER_MACROS_SVH
`define SERVO_ACK_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SAFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SAFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/safp_pkg.sv =====
// Shared constants, codes and helpers for the servo acknowledge frame parser.
// No dependencies; used by the parser top level.
package safp_pkg;

    // Default and upper bound of the payload buffer depth
    localparam int MAX_DATA_DEF = 32;

    // Frame layout constants
    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] CSUM_MASK   = 8'hFE;
    localparam int         HDR_LEN     = 7;

    // Result kinds
    localparam logic [2:0] KIND_GOOD    = 3'd0;
    localparam logic [2:0] KIND_UNK_CMD = 3'd1;
    localparam logic [2:0] KIND_CS2_ERR = 3'd2;
    localparam logic [2:0] KIND_CS1_ERR = 3'd3;
    localparam logic [2:0] KIND_BAD_SIZE = 3'd4;

    // Acknowledge command codes
    localparam logic [7:0] CMD_EEP_WRITE = 8'h41;
    localparam logic [7:0] CMD_EEP_READ  = 8'h42;
    localparam logic [7:0] CMD_RAM_WRITE = 8'h43;
    localparam logic [7:0] CMD_RAM_READ  = 8'h44;
    localparam logic [7:0] CMD_STAT      = 8'h47;
    localparam logic [7:0] CMD_ROLLBACK  = 8'h48;
    localparam logic [7:0] CMD_REBOOT    = 8'h49;

    // One result item as held in the output register
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] unit_id;
        logic [7:0] command;
        logic       has_data;
        logic [7:0] data_byte;
        logic [4:0] data_index;
        logic       last;
    } result_t;

    // Flag the acknowledge command codes
    function automatic logic is_ack(input logic [7:0] c);
        logic hit;
        hit = (c == CMD_EEP_WRITE) || (c == CMD_EEP_READ) || (c == CMD_RAM_WRITE) ||
              (c == CMD_RAM_READ) || (c == CMD_STAT) || (c == CMD_ROLLBACK) ||
              (c == CMD_REBOOT);
        return hit;
    endfunction

endpackage

// ===== src/safp_if.sv =====
// Valid/ready channel interfaces for the servo acknowledge frame parser.
// Byte request channel and result request channel; no dependencies.
interface safp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface safp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] unit_id;
    logic [7:0] command;
    logic       has_data;
    logic [7:0] data_byte;
    logic [4:0] data_index;
    logic       last;

    modport source (output valid, output kind, output unit_id, output command,
                    output has_data, output data_byte, output data_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input unit_id, input command,
                    input has_data, input data_byte, input data_index,
                    input last, output ready);
endinterface

// ===== src/safp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the payload bytes of the parser.
module safp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold the last word between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/servo_ack_frame_parser.sv =====
// Servo acknowledge frame parser: byte-level frame state machine and payload replay.
// Depends on safp_pkg, safp_if and safp_ram; assertions from the macros header.
//
// Usage:
//   rx  : one received serial byte per request (valid/ready, rx_byte).
//   res : result requests (valid/ready) carrying kind, unit_id, command,
//         has_data, data_byte, data_index and last.
//   cfg_we/cfg_wdata write report_errors (reset 1); write only while idle.
// A status result, or the single result of a good frame without payload, is
// loaded into the output register on the edge that takes the byte completing
// it. A good frame with payload is replayed from the payload RAM: each result
// is read from the RAM, then loaded into the output register once that frees;
// rx is held off until the last payload result of the frame is loaded.
// rx stays ready while a result waits, except for bytes that may close a frame
// (size, command, checksum2, payload), which wait until the output register
// frees. Reset returns to hunting the first 0xFF header byte with the output
// empty; the payload RAM needs no clearing, as only entries written within the
// current frame are read.
`include "servo_ack_frame_parser_macros.svh"

module servo_ack_frame_parser #(
    parameter int MAX_DATA = safp_pkg::MAX_DATA_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    safp_rx_if.sink          rx,
    safp_res_if.source       res
);
    import safp_pkg::*;

    localparam int AW       = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int CW       = $clog2(MAX_DATA + 1);
    localparam int SIZE_MAX = HDR_LEN + MAX_DATA;

    // Frame parse states
    localparam logic [2:0] ST_HUNT1 = 3'd0;
    localparam logic [2:0] ST_HUNT2 = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_ID    = 3'd3;
    localparam logic [2:0] ST_CMD   = 3'd4;
    localparam logic [2:0] ST_CS1   = 3'd5;
    localparam logic [2:0] ST_CS2   = 3'd6;
    localparam logic [2:0] ST_DATA  = 3'd7;

    // Replay phases
    localparam logic [1:0] PH_PARSE = 2'd0;
    localparam logic [1:0] PH_RD    = 2'd1;
    localparam logic [1:0] PH_LOAD  = 2'd2;

    logic [2:0]    st_reg, st_next;
    logic [1:0]    ph_reg, ph_next;
    logic          rep_err_reg;
    logic [7:0]    size_reg, size_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    cs1_reg, cs1_next;
    logic [7:0]    xor_reg, xor_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          acc;
    logic          emit_st;
    logic          out_free;
    logic          load_parse;
    logic          load_rep;
    result_t       pk;
    logic [7:0]    c;
    logic [7:0]    xor_data;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic          rep_last;

    assign c        = rx.rx_byte;
    assign out_free = !out_valid_reg || res.ready;
    assign emit_st  = (st_reg == ST_SIZE) || (st_reg == ST_CMD) ||
                      (st_reg == ST_CS2) || (st_reg == ST_DATA);
    assign rx.ready = (ph_reg == PH_PARSE) && (out_free || !emit_st);
    assign acc      = rx.valid && rx.ready;
    assign xor_data = xor_reg ^ c;
    assign rep_last = ((idx_reg + CW'(1)) == cnt_reg);

    // Payload store
    safp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DATA)
    ) u_payload (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (c),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Parse one byte and sequence the payload replay
    always_comb
    begin
        st_next    = st_reg;
        ph_next    = ph_reg;
        size_next  = size_reg;
        id_next    = id_reg;
        cmd_next   = cmd_reg;
        cs1_next   = cs1_reg;
        xor_next   = xor_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        load_parse = 1'b0;
        load_rep   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        pk         = '0;
        pk.last    = 1'b1;

        if (acc)
        begin
            case (st_reg)
                ST_HUNT1:
                begin
                    if (c == HEADER_BYTE)
                    begin
                        st_next = ST_HUNT2;
                    end
                end
                ST_HUNT2:
                begin
                    st_next = (c == HEADER_BYTE) ? ST_SIZE : ST_HUNT1;
                end
                ST_SIZE:
                begin
                    if ((c < 8'(HDR_LEN)) || (c > 8'(SIZE_MAX)))
                    begin
                        st_next    = ST_HUNT1;
                        load_parse = rep_err_reg;
                        pk.kind    = KIND_BAD_SIZE;
                    end
                    else
                    begin
                        size_next = c;
                        xor_next  = c;
                        cnt_next  = '0;
                        st_next   = ST_ID;
                    end
                end
                ST_ID:
                begin
                    id_next  = c;
                    xor_next = xor_data;
                    st_next  = ST_CMD;
                end
                ST_CMD:
                begin
                    if (!is_ack(c))
                    begin
                        st_next     = ST_HUNT1;
                        load_parse  = rep_err_reg;
                        pk.kind     = KIND_UNK_CMD;
                        pk.unit_id  = id_reg;
                        pk.command  = c;
                    end
                    else
                    begin
                        cmd_next = c;
                        xor_next = xor_data;
                        st_next  = ST_CS1;
                    end
                end
                ST_CS1:
                begin
                    cs1_next = c;
                    st_next  = ST_CS2;
                end
                ST_CS2:
                begin
                    pk.unit_id  = id_reg;
                    pk.command  = cmd_reg;
                    if (c != (~cs1_reg & CSUM_MASK))
                    begin
                        st_next    = ST_HUNT1;
                        load_parse = rep_err_reg;
                        pk.kind    = KIND_CS2_ERR;
                    end
                    else if (size_reg <= 8'(HDR_LEN))
                    begin
                        // Frame without payload closes here
                        st_next = ST_HUNT1;
                        if ((xor_reg & CSUM_MASK) != cs1_reg)
                        begin
                            load_parse = rep_err_reg;
                            pk.kind    = KIND_CS1_ERR;
                        end
                        else
                        begin
                            load_parse = 1'b1;
                            pk.kind    = KIND_GOOD;
                        end
                    end
                    else
                    begin
                        st_next = ST_DATA;
                    end
                end
                default:
                begin
                    // Payload byte: store, fold into the checksum, close on the last
                    ram_we   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    xor_next = xor_data;
                    if ((8'(cnt_next) + 8'(HDR_LEN)) >= size_reg)
                    begin
                        st_next = ST_HUNT1;
                        if ((xor_data & CSUM_MASK) != cs1_reg)
                        begin
                            load_parse  = rep_err_reg;
                            pk.kind     = KIND_CS1_ERR;
                            pk.unit_id  = id_reg;
                            pk.command  = cmd_reg;
                        end
                        else
                        begin
                            ph_next  = PH_RD;
                            idx_next = '0;
                        end
                    end
                end
            endcase
        end

        // Replay stored payload: read, then load when the output frees
        case (ph_reg)
            PH_PARSE:
            begin
            end
            PH_RD:
            begin
                ram_re  = 1'b1;
                ph_next = PH_LOAD;
            end
            PH_LOAD:
            begin
                if (out_free)
                begin
                    load_rep = 1'b1;
                    if (rep_last)
                    begin
                        ph_next = PH_PARSE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        ph_next  = PH_RD;
                    end
                end
            end
            default:
            begin
                ph_next = PH_PARSE;
            end
        endcase
    end

    // Output register next value
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        if (load_parse)
        begin
            out_next       = pk;
            out_valid_next = 1'b1;
        end
        else if (load_rep)
        begin
            out_next.kind       = KIND_GOOD;
            out_next.unit_id    = id_reg;
            out_next.command    = cmd_reg;
            out_next.has_data   = 1'b1;
            out_next.data_byte  = ram_rdata;
            out_next.data_index = 5'(idx_reg[AW-1:0]);
            out_next.last       = rep_last;
            out_valid_next      = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_HUNT1;
            ph_reg        <= PH_PARSE;
            rep_err_reg   <= 1'b1;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                rep_err_reg <= cfg_wdata;
            end
        end
    end

    // Held frame fields and output payload
    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        id_reg   <= id_next;
        cmd_reg  <= cmd_next;
        cs1_reg  <= cs1_next;
        xor_reg  <= xor_next;
        out_reg  <= out_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = out_reg.kind;
    assign res.unit_id    = out_reg.unit_id;
    assign res.command    = out_reg.command;
    assign res.has_data   = out_reg.has_data;
    assign res.data_byte  = out_reg.data_byte;
    assign res.data_index = out_reg.data_index;
    assign res.last       = out_reg.last;

    // Checks on the replay and output logic
    `SAFP_ASSERT_NOW(a_no_rx_in_replay, ph_reg != PH_PARSE, !rx.ready, "byte taken during replay")
    `SAFP_ASSERT_NOW(a_idx_in_range, ph_reg != PH_PARSE, idx_reg < cnt_reg, "replay index past count")
    `SAFP_ASSERT_NEXT(a_load_waits, (ph_reg == PH_LOAD) && out_valid_reg && !res.ready, ph_reg == PH_LOAD, "replay left load while output blocked")
    `SAFP_ASSERT_NOW(a_data_is_good, out_valid_reg && out_reg.has_data, out_reg.kind == KIND_GOOD, "payload result with error kind")

endmodule

// ===== verif/servo_ack_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// Checker for the servo acknowledge frame parser: watches the byte, result and register
// ports, predicts every result request and compares it. Depends on safp_pkg and safp_if.
module servo_ack_frame_parser_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    safp_rx_if   rx,
    safp_res_if  res,
    output int   fail_count,
    output int   pending
);
    import safp_pkg::*;

    typedef enum logic [2:0] {
        WAIT_HDR1,
        WAIT_HDR2,
        TAKE_SIZE,
        TAKE_ID,
        TAKE_CMD,
        TAKE_CS1,
        TAKE_CS2,
        TAKE_DATA
    } frame_step_t;

    frame_step_t step_now;
    logic        report_drops;
    logic [7:0]  frame_size;
    logic [7:0]  frame_id;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_cs1;
    logic [7:0]  frame_xor;
    int          payload_len;
    logic [7:0]  payload_copy [MAX_DATA_DEF];
    result_t     results_due [$];

    // Queue a lone result: a status, or a good frame without payload
    function automatic void queue_status(input logic [2:0] code, input logic [7:0] id,
                                         input logic [7:0] cmd);
        result_t r;
        r = '{kind: code, unit_id: id, command: cmd, has_data: 1'b0,
              data_byte: 8'h00, data_index: 5'd0, last: 1'b1};
        results_due.push_back(r);
    endfunction

    // Drop the frame and go back to hunting; report it if enabled
    function automatic void drop_frame(input logic [2:0] code, input logic [7:0] id,
                                       input logic [7:0] cmd);
        step_now = WAIT_HDR1;
        if (report_drops)
            queue_status(code, id, cmd);
    endfunction

    // Check checksum1 over size, id, command and payload, then queue the good result or payload run
    function automatic void close_frame();
        result_t r;
        step_now = WAIT_HDR1;
        if ((frame_xor & CSUM_MASK) != frame_cs1)
            drop_frame(KIND_CS1_ERR, frame_id, frame_cmd);
        else if (payload_len == 0)
            queue_status(KIND_GOOD, frame_id, frame_cmd);
        else
        begin
            for (int k = 0; k < payload_len; k++)
            begin
                r = '{kind: KIND_GOOD, unit_id: frame_id, command: frame_cmd,
                      has_data: 1'b1, data_byte: payload_copy[k], data_index: 5'(k),
                      last: (k == payload_len - 1)};
                results_due.push_back(r);
            end
        end
    endfunction

    // Advance the frame parse by one received byte
    function automatic void parse_rx_byte(input logic [7:0] b);
        logic known;
        case (step_now)
            WAIT_HDR1:
                if (b == HEADER_BYTE)
                    step_now = WAIT_HDR2;
            WAIT_HDR2:
                step_now = (b == HEADER_BYTE) ? TAKE_SIZE : WAIT_HDR1;
            TAKE_SIZE:
                if (b < HDR_LEN || b > HDR_LEN + MAX_DATA_DEF)
                    drop_frame(KIND_BAD_SIZE, 8'h00, 8'h00);
                else
                begin
                    frame_size  = b;
                    frame_xor   = b;
                    payload_len = 0;
                    step_now    = TAKE_ID;
                end
            TAKE_ID:
            begin
                frame_id  = b;
                frame_xor = frame_xor ^ b;
                step_now  = TAKE_CMD;
            end
            TAKE_CMD:
            begin
                case (b)
                    CMD_EEP_WRITE, CMD_EEP_READ, CMD_RAM_WRITE, CMD_RAM_READ,
                    CMD_STAT, CMD_ROLLBACK, CMD_REBOOT: known = 1'b1;
                    default: known = 1'b0;
                endcase
                if (!known)
                    drop_frame(KIND_UNK_CMD, frame_id, b);
                else
                begin
                    frame_cmd = b;
                    frame_xor = frame_xor ^ b;
                    step_now  = TAKE_CS1;
                end
            end
            TAKE_CS1:
            begin
                frame_cs1 = b;
                step_now  = TAKE_CS2;
            end
            TAKE_CS2:
                if (b != (~frame_cs1 & CSUM_MASK))
                    drop_frame(KIND_CS2_ERR, frame_id, frame_cmd);
                else if (frame_size <= HDR_LEN)
                    close_frame();
                else
                    step_now = TAKE_DATA;
            default:
            begin
                // Hold the payload byte; the frame closes on its declared size
                if (payload_len < MAX_DATA_DEF)
                begin
                    payload_copy[payload_len] = b;
                    payload_len++;
                end
                frame_xor = frame_xor ^ b;
                if (payload_len + HDR_LEN >= frame_size || payload_len >= MAX_DATA_DEF)
                    close_frame();
            end
        endcase
    endfunction

    // Compare each result request with the oldest one due, then predict from the byte
    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        result_t want;
        logic    bad;
        if (!rst_n)
        begin
            step_now     = WAIT_HDR1;
            report_drops = 1'b1;
            frame_size   = 8'h00;
            frame_id     = 8'h00;
            frame_cmd    = 8'h00;
            frame_cs1    = 8'h00;
            frame_xor    = 8'h00;
            payload_len  = 0;
            results_due.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
                report_drops = cfg_wdata;
            if (res.valid && res.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with none due: kind %0d, unit_id %0h, command %0h",
                           res.kind, res.unit_id, res.command);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    bad  = 1'b0;
                    if (res.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, res.kind);
                        bad = 1'b1;
                    end
                    if (res.unit_id !== want.unit_id)
                    begin
                        $error("unit_id: expected %0h, actual %0h",
                               want.unit_id, res.unit_id);
                        bad = 1'b1;
                    end
                    if (res.command !== want.command)
                    begin
                        $error("command: expected %0h, actual %0h",
                               want.command, res.command);
                        bad = 1'b1;
                    end
                    if (res.has_data !== want.has_data)
                    begin
                        $error("has_data: expected %0d, actual %0d",
                               want.has_data, res.has_data);
                        bad = 1'b1;
                    end
                    if (res.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %0h, actual %0h",
                               want.data_byte, res.data_byte);
                        bad = 1'b1;
                    end
                    if (res.data_index !== want.data_index)
                    begin
                        $error("data_index: expected %0d, actual %0d",
                               want.data_index, res.data_index);
                        bad = 1'b1;
                    end
                    if (res.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, res.last);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
            if (rx.valid && rx.ready)
                parse_rx_byte(rx.rx_byte);
            pending = results_due.size();
        end
    end

endmodule

// ===== verif/servo_ack_frame_parser_test.sv =====
`timescale 1ns / 1ps
// Top of the servo acknowledge frame parser testbench: clock, reset, byte and result
// stimulus and the verdict. Depends on safp_pkg, safp_if and the checker module.
module servo_ack_frame_parser_test;
    import safp_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 2 * MAX_DATA_DEF + 16;
    localparam int PHASE_BYTES     = 95;

    typedef enum int {
        DMG_NONE,
        DMG_BAD_HDR2,
        DMG_BAD_SIZE,
        DMG_UNK_CMD,
        DMG_BAD_CS2,
        DMG_BAD_CS1,
        DMG_TRUNCATED,
        DMG_NOISE
    } damage_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    int         fail_count;
    int         pending;
    int         cycle_count;
    int         burst_left;
    int         gap_left;
    int         frame_serial;
    int         holds_asked;
    int         holds_served;
    logic [7:0] byte_queue [$];
    logic [7:0] ack_codes [7];

    safp_rx_if  rx_ch ();
    safp_res_if res_ch ();

    servo_ack_frame_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    servo_ack_frame_parser_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rx         (rx_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stall result requests on a changing pattern; hold off for a long stretch on demand
    initial
    begin : receiver_pattern
        int mode;
        int mode_left;
        int tick;
        res_ch.ready = 1'b0;
        holds_served = 0;
        mode         = 0;
        mode_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served < holds_asked)
            begin
                holds_served++;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= (tick % 3 != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Append one frame, damaged as asked, to the bytes waiting to go out
    function automatic void queue_frame(input damage_t dmg, input int len,
                                        input logic [7:0] id, input logic [7:0] cmd);
        logic [7:0] body [$];
        logic [7:0] whole [$];
        logic [7:0] size;
        logic [7:0] sum;
        logic [7:0] cs1;
        logic [7:0] cs2;
        int         cut;
        size = 8'(HDR_LEN + len);
        sum  = size ^ id ^ cmd;
        for (int k = 0; k < len; k++)
        begin
            body.push_back(8'($urandom));
            sum = sum ^ body[k];
        end
        cs1 = sum & CSUM_MASK;
        if (dmg == DMG_BAD_CS1)
            cs1 = cs1 ^ 8'(1 << $urandom_range(0, 7));
        cs2 = ~cs1 & CSUM_MASK;
        if (dmg == DMG_BAD_CS2)
            cs2 = cs2 ^ 8'(1 << $urandom_range(0, 7));
        case (dmg)
            DMG_BAD_HDR2:
            begin
                byte_queue.push_back(HEADER_BYTE);
                byte_queue.push_back(8'($urandom_range(0, 254)));
            end
            DMG_BAD_SIZE:
            begin
                byte_queue.push_back(HEADER_BYTE);
                byte_queue.push_back(HEADER_BYTE);
                if ($urandom_range(0, 1) != 0)
                    byte_queue.push_back(8'($urandom_range(0, HDR_LEN - 1)));
                else
                    byte_queue.push_back(8'($urandom_range(HDR_LEN + MAX_DATA_DEF + 1, 255)));
            end
            DMG_UNK_CMD:
            begin
                byte_queue.push_back(HEADER_BYTE);
                byte_queue.push_back(HEADER_BYTE);
                byte_queue.push_back(size);
                byte_queue.push_back(id);
                byte_queue.push_back(cmd);
            end
            DMG_NOISE:
                repeat ($urandom_range(1, 6)) byte_queue.push_back(8'($urandom));
            default:
            begin
                whole = {HEADER_BYTE, HEADER_BYTE, size, id, cmd, cs1, cs2};
                foreach (body[k])
                    whole.push_back(body[k]);
                // Truncate: the next frame's bytes then land in this one
                cut = (dmg == DMG_TRUNCATED) ? $urandom_range(1, whole.size() - 3) : 0;
                for (int k = 0; k < whole.size() - cut; k++)
                    byte_queue.push_back(whole[k]);
            end
        endcase
    endfunction

    // Offer the waiting bytes as requests, in bursts with random gaps
    task automatic send_queued();
        logic [7:0] b;
        while (byte_queue.size() > 0)
        begin
            b = byte_queue.pop_front();
            if (gap_left > 0)
            begin
                rx_ch.valid <= 1'b0;
                while (gap_left > 0)
                begin
                    @(negedge clk);
                    gap_left--;
                end
            end
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= b;
            do
                @(posedge clk);
            while (!rx_ch.ready);
            @(negedge clk);
            burst_left--;
            if (burst_left <= 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(1, 4);
                    end
                    6, 7:
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(5, 20);
                    end
                    default:
                    begin
                        burst_left = 40;
                        gap_left   = 0;
                    end
                endcase
            end
        end
        rx_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Pause the sender until every result is in, then let the block settle
    task automatic drain_results();
        wait (pending == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_report_errors(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed frames with random content, the rest damaged or noise
    task automatic run_random_phase(input int budget);
        int         pick;
        int         len;
        logic [7:0] cmd;
        damage_t    dmg;
        while (byte_queue.size() < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 4);
                6, 7, 8: len = $urandom_range(5, 12);
                default: len = $urandom_range(13, MAX_DATA_DEF);
            endcase
            if (frame_serial % 23 == 11)
                len = MAX_DATA_DEF;
            cmd  = (frame_serial < 7) ? ack_codes[frame_serial] : ack_codes[$urandom_range(0, 6)];
            pick = $urandom_range(0, 99);
            if (pick < 55)
                dmg = DMG_NONE;
            else if (pick < 61)
                dmg = DMG_BAD_HDR2;
            else if (pick < 67)
                dmg = DMG_BAD_SIZE;
            else if (pick < 74)
                dmg = DMG_UNK_CMD;
            else if (pick < 80)
                dmg = DMG_BAD_CS2;
            else if (pick < 87)
                dmg = DMG_BAD_CS1;
            else if (pick < 93)
                dmg = DMG_TRUNCATED;
            else
                dmg = DMG_NOISE;
            // Unknown commands: below, between and above the acknowledge codes
            if (dmg == DMG_UNK_CMD)
            begin
                case ($urandom_range(0, 2))
                    0: cmd = 8'($urandom_range(0, CMD_EEP_WRITE - 1));
                    1: cmd = 8'($urandom_range(CMD_RAM_READ + 1, CMD_STAT - 1));
                    default: cmd = 8'($urandom_range(CMD_REBOOT + 1, 255));
                endcase
            end
            queue_frame(dmg, len, 8'($urandom), cmd);
            frame_serial++;
        end
        send_queued();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        holds_asked   = 0;
        burst_left    = 8;
        gap_left      = 0;
        frame_serial  = 0;
        ack_codes     = '{CMD_EEP_WRITE, CMD_EEP_READ, CMD_RAM_WRITE, CMD_RAM_READ,
                          CMD_STAT, CMD_ROLLBACK, CMD_REBOOT};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: broken second header, sizes just outside the range, unknown command,
        // checksum2 mismatch and a good frame with no payload
        write_report_errors(1'b1);
        byte_queue.push_back(HEADER_BYTE);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(HEADER_BYTE);
        byte_queue.push_back(HEADER_BYTE);
        byte_queue.push_back(8'(HDR_LEN - 1));
        byte_queue.push_back(HEADER_BYTE);
        byte_queue.push_back(HEADER_BYTE);
        byte_queue.push_back(8'(HDR_LEN + MAX_DATA_DEF + 1));
        queue_frame(DMG_UNK_CMD, 0, 8'hFF, 8'h00);
        queue_frame(DMG_BAD_CS2, 0, 8'h00, CMD_EEP_WRITE);
        queue_frame(DMG_NONE, 0, 8'hA5, CMD_STAT);
        send_queued();
        drain_results();

        // Hold the receiver off while a payload frame and more bytes keep coming
        holds_asked++;
        queue_frame(DMG_NONE, 12, 8'($urandom), CMD_RAM_READ);
        run_random_phase(PHASE_BYTES);
        drain_results();

        // Drop damaged frames silently
        write_report_errors(1'b0);
        run_random_phase(PHASE_BYTES);
        drain_results();

        write_report_errors(1'b1);
        run_random_phase(PHASE_BYTES);
        drain_results();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
